### design/frca_pkg.sv
// ----------------------------------------------------------------------------
// frca_pkg
// Shared types, constants and the bytewise CRC-16 update for the fragment
// reassembly CRC check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package frca_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
	localparam int SUM_W        = ((CNT_W > 8) ? CNT_W : 8) + 1;
	localparam int FILE_BYTES_W = 13;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// input mode codes
	localparam logic [1:0] MODE_BYTE      = 2'd0;
	localparam logic [1:0] MODE_RADIO_ERR = 2'd1;
	localparam logic [1:0] MODE_READ_ERR  = 2'd2;
	localparam logic [1:0] MODE_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_RADIO_ERR,
		KIND_READ_ERR,
		KIND_EMPTY
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_SHORT,
		ST_NO_CRC,
		ST_MISSED_FIRST,
		ST_RADIO_ERR,
		ST_READ_ERR,
		ST_EMPTY
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] packet_len;
	} item_t;

	typedef struct packed {
		status_t                   packet_status;
		logic [7:0]                fragment_index;
		logic [7:0]                fragment_total;
		logic                      payload_stored;
		logic                      file_done;
		logic                      crc_match;
		logic [15:0]               computed_crc;
		logic [15:0]               expected_crc_out;
		logic [FILE_BYTES_W-1:0]   file_bytes;
	} result_t;

	function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### design/frca_front.sv
// ----------------------------------------------------------------------------
// frca_front
// Input side: takes stream transfers and sorts them into byte items and
// event items before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module frca_front (
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [1:0]      mode,
	input  wire logic [7:0]      data_byte,
	input  wire logic [7:0]      packet_len,
	input  wire logic            queue_full,
	output logic                 push,
	output frca_pkg::item_t      item
);
	import frca_pkg::*;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	always_comb begin
		unique case (mode)
			MODE_RADIO_ERR: item.kind = KIND_RADIO_ERR;
			MODE_READ_ERR:  item.kind = KIND_READ_ERR;
			MODE_EMPTY:     item.kind = KIND_EMPTY;
			default: begin
				// a data byte of a zero-length packet counts as an empty packet
				item.kind = (packet_len == 8'd0) ? KIND_EMPTY : KIND_BYTE;
			end
		endcase
		item.data_byte  = data_byte;
		item.packet_len = packet_len;
	end

endmodule

`default_nettype wire

### design/frca_queue.sv
// ----------------------------------------------------------------------------
// frca_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module frca_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire frca_pkg::item_t  push_item,
	input  wire logic             pop,
	output frca_pkg::item_t       pop_item,
	output logic                  full,
	output logic                  empty
);
	import frca_pkg::*;

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/frca_back.sv
// ----------------------------------------------------------------------------
// frca_back
// Execution side: walks each packet byte by byte, tracks the header, runs
// the CRC over accepted payload bytes and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module frca_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             queue_empty,
	input  wire frca_pkg::item_t  item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output frca_pkg::result_t     result
);
	import frca_pkg::*;

	logic [15:0]       crc_q;
	logic [15:0]       exp_crc_q;
	logic [CNT_W-1:0]  count_q;
	logic [7:0]        pos_q;
	logic [7:0]        hidx_q;
	logic [7:0]        htot_q;
	logic [7:0]        crc_hi_q;
	logic              store_en_q;
	logic              rejected_q;
	logic              valid_q;
	result_t           result_q;

	logic [15:0]       crc_n;
	logic [15:0]       exp_crc_n;
	logic [CNT_W-1:0]  count_n;
	logic [7:0]        pos_n;
	logic [7:0]        hidx_n;
	logic [7:0]        htot_n;
	logic [7:0]        crc_hi_n;
	logic              store_en_n;
	logic              rejected_n;
	logic              emit;
	result_t           res;
	logic [7:0]        payload;
	logic [SUM_W-1:0]  fill_sum;
	logic              done;

	assign pop      = !queue_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign result   = result_q;

	always_comb begin
		crc_n      = crc_q;
		exp_crc_n  = exp_crc_q;
		count_n    = count_q;
		pos_n      = pos_q;
		hidx_n     = hidx_q;
		htot_n     = htot_q;
		crc_hi_n   = crc_hi_q;
		store_en_n = store_en_q;
		rejected_n = rejected_q;
		emit       = 1'b0;
		payload    = '0;
		fill_sum   = '0;
		done       = 1'b0;
		res        = '0;

		if (item.kind != KIND_BYTE) begin
			pos_n      = '0;
			store_en_n = 1'b0;
			rejected_n = 1'b0;
			emit       = 1'b1;
			case (item.kind)
				KIND_RADIO_ERR: res.packet_status = ST_RADIO_ERR;
				KIND_READ_ERR:  res.packet_status = ST_READ_ERR;
				default:        res.packet_status = ST_EMPTY;
			endcase
		end else if (pos_q == 8'd0 && item.packet_len == 8'd1) begin
			hidx_n            = item.data_byte;
			store_en_n        = 1'b0;
			rejected_n        = 1'b0;
			pos_n             = '0;
			emit              = 1'b1;
			res.packet_status = ST_TOO_SHORT;
		end else begin
			if (pos_q == 8'd0) begin
				hidx_n     = item.data_byte;
				store_en_n = 1'b0;
				rejected_n = 1'b0;
			end else if (pos_q == 8'd1) begin
				htot_n = item.data_byte;
				if (hidx_q == 8'd0) begin
					count_n = '0;
					crc_n   = CRC_INIT;
					if (item.packet_len >= 8'd4) begin
						payload = item.packet_len - 8'd4;
					end
				end else if (count_q == '0) begin
					rejected_n = 1'b1;
				end else begin
					payload = item.packet_len - 8'd2;
				end
				fill_sum   = SUM_W'(count_n) + SUM_W'(payload);
				store_en_n = !rejected_n && (payload != 8'd0) &&
					(fill_sum <= SUM_W'(BUFFER_BYTES));
			end else if (hidx_q == 8'd0 && pos_q < 8'd4) begin
				if (pos_q == 8'd2) begin
					crc_hi_n = item.data_byte;
				end else begin
					exp_crc_n = {crc_hi_q, item.data_byte};
				end
			end else if (store_en_q) begin
				crc_n   = crc_feed(crc_q, item.data_byte);
				count_n = count_q + 1'b1;
			end

			if ({1'b0, pos_q} + 9'd1 < {1'b0, item.packet_len}) begin
				pos_n = pos_q + 8'd1;
			end else begin
				// end of packet: report and close it
				pos_n = '0;
				emit  = 1'b1;
				if (rejected_n) begin
					res.packet_status = ST_MISSED_FIRST;
				end else begin
					res.packet_status = (hidx_n == 8'd0 && item.packet_len < 8'd4) ?
						ST_NO_CRC : ST_OK;
					done = (htot_n != 8'd0) &&
						({1'b0, hidx_n} + 9'd1 == {1'b0, htot_n});
				end
				res.fragment_index = hidx_n;
				res.fragment_total = htot_n;
				res.payload_stored = store_en_n;
				res.file_done      = done;
				res.crc_match      = done && (crc_n == exp_crc_n);
				store_en_n         = 1'b0;
				rejected_n         = 1'b0;
			end
		end

		res.computed_crc     = crc_n;
		res.expected_crc_out = exp_crc_n;
		res.file_bytes       = FILE_BYTES_W'(count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			exp_crc_q  <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			hidx_q     <= '0;
			htot_q     <= '0;
			crc_hi_q   <= '0;
			store_en_q <= 1'b0;
			rejected_q <= 1'b0;
			valid_q    <= 1'b0;
		end else if (pop) begin
			crc_q      <= crc_n;
			exp_crc_q  <= exp_crc_n;
			count_q    <= count_n;
			pos_q      <= pos_n;
			hidx_q     <= hidx_n;
			htot_q     <= htot_n;
			crc_hi_q   <= crc_hi_n;
			store_en_q <= store_en_n;
			rejected_q <= rejected_n;
			valid_q    <= emit;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result_q <= res;
		end
	end

endmodule

`default_nettype wire

### design/fragment_reassembly_crc_check_unit.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_crc_check_unit
// Reassembles fragmented radio packets and checks the CRC-16 of the file.
// ----------------------------------------------------------------------------
// m_tvalid and the result are registered when the back pops a packet's last item
// throughput: one input transfer per cycle while the queue is not full; the
// back part handles one queue entry per cycle, including the full bytewise
// crc update, while no result waits on m_tready
// reset: arst_n clears the queue, the result valid flag and all header,
// count and crc state (crc to 0xffff); no clearing pass is needed
`default_nettype none

module fragment_reassembly_crc_check_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // data_byte[7:0], packet_len[15:8]
	input  wire logic [1:0]   s_tuser,   // mode[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// fragment_index[7:0], fragment_total[15:8], payload_stored[16],
	// file_done[17], crc_match[18], computed_crc[34:19],
	// expected_crc_out[50:35], file_bytes[63:51]
	output logic [63:0]       m_tdata,
	output logic [2:0]        m_tuser    // packet_status[2:0]
);
	import frca_pkg::*;

	item_t    push_item;
	item_t    pop_item;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	result_t  res;

	frca_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.mode       (s_tuser),
		.data_byte  (s_tdata[7:0]),
		.packet_len (s_tdata[15:8]),
		.queue_full (full),
		.push       (push),
		.item       (push_item)
	);

	frca_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (full),
		.empty     (empty)
	);

	frca_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (empty),
		.item        (pop_item),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.result      (res)
	);

	assign m_tuser = res.packet_status;
	assign m_tdata = {res.file_bytes, res.expected_crc_out, res.computed_crc,
		res.crc_match, res.file_done, res.payload_stored,
		res.fragment_total, res.fragment_index};

	// a crc match is only reported together with a finished file
	a_match_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.crc_match |-> res.file_done)
		else $error("crc_match without file_done");

	// a file can only finish on a packet that was not rejected
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.file_done |->
			(res.packet_status == ST_OK || res.packet_status == ST_NO_CRC))
		else $error("file_done with an error status");

	// event and too-short results carry no header and store nothing
	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.packet_status == ST_RADIO_ERR ||
			res.packet_status == ST_READ_ERR || res.packet_status == ST_EMPTY ||
			res.packet_status == ST_TOO_SHORT) |->
			(res.fragment_index == 8'd0 && res.fragment_total == 8'd0 &&
			!res.payload_stored && !res.file_done))
		else $error("event result with header or store flags");

	// the queue only refuses input once it holds entries the back has not taken
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> !empty)
		else $error("input stalled with an empty queue");

endmodule

`default_nettype wire
